// ----- sv/cpu_bus_memory_responder_core_macros.svh -----
// Assertion macros for the bus memory responder checker.
// Both sample on clk; the names clk and rst_n must exist where they are used.
`ifndef CPU_BUS_MEMORY_RESPONDER_CORE_MACROS_SVH
`define CPU_BUS_MEMORY_RESPONDER_CORE_MACROS_SVH

// Next-cycle implication, ignored while reset is asserted.
`define CBMR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbmr assertion failed");

// Next-cycle implication that also holds across reset.
`define CBMR_ASSERT_NEXT_ANY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cbmr assertion failed");

`endif

// ----- sv/cbmr_pkg.sv -----
package cbmr_pkg;

  localparam int CBMR_STORE_DEPTH = 131072;
  localparam int CBMR_STEP_LIMIT  = 100000;

  localparam int ADDR_W  = 17;   // full effective address, bank bit included
  localparam int COUNT_W = 17;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = 17'd100000;
  localparam logic [COUNT_W-1:0] RST_CD_INIT = 17'd6;

  typedef enum logic [2:0] {
    ACT_BUS        = 3'd0,
    ACT_LOAD_RESET = 3'd1,
    ACT_LOAD_NMI   = 3'd2,
    ACT_LOAD_IRQ   = 3'd3,
    ACT_LOAD_STEPS = 3'd4,
    ACT_HOST_WRITE = 3'd5
  } action_t;

  typedef enum logic [0:0] {
    REG_BANK_ENABLE = 1'b0,
    REG_HOST_BANK   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [15:0]        bus_address;
    logic [7:0]         bank_byte;
    logic               is_read;
    logic [7:0]         data_byte;
    logic [COUNT_W-1:0] count_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic               ready_res;
    logic               reset_active;
    logic               nmi_active;
    logic               irq_active;
    logic [COUNT_W-1:0] steps_left;
  } out_item_t;

  // Line levels and budget as seen by the result path.
  typedef struct packed {
    logic               ready;
    logic               reset_act;
    logic               nmi_act;
    logic               irq_act;
    logic [COUNT_W-1:0] steps;
  } ctrl_stat_t;

endpackage

// ----- sv/cbmr_store.sv -----
module cbmr_store
  import cbmr_pkg::*;
#(
  parameter int STORE_DEPTH = CBMR_STORE_DEPTH,
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem_r [STORE_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/cbmr_ctrl.sv -----
module cbmr_ctrl
  import cbmr_pkg::*;
#(
  parameter int STEP_LIMIT = CBMR_STEP_LIMIT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [2:0]         action,
  input  logic [COUNT_W-1:0] count_value,
  output ctrl_stat_t         stat
);

  logic [COUNT_W-1:0] rst_cd_r, rst_cd_nxt;
  logic [COUNT_W-1:0] nmi_cd_r, nmi_cd_nxt;
  logic [COUNT_W-1:0] irq_cd_r, irq_cd_nxt;
  logic [COUNT_W-1:0] steps_r, steps_nxt;
  logic               ready_r, ready_nxt;
  logic               rst_act_r, rst_act_nxt;
  logic               nmi_act_r, nmi_act_nxt;
  logic               irq_act_r, irq_act_nxt;
  logic [COUNT_W-1:0] sat;

  assign sat = (count_value > COUNT_MAX) ? COUNT_MAX : count_value;

  always_comb begin
    rst_cd_nxt  = rst_cd_r;
    nmi_cd_nxt  = nmi_cd_r;
    irq_cd_nxt  = irq_cd_r;
    steps_nxt   = steps_r;
    ready_nxt   = ready_r;
    rst_act_nxt = rst_act_r;
    nmi_act_nxt = nmi_act_r;
    irq_act_nxt = irq_act_r;
    if (accept) begin
      case (action)
        ACT_BUS: begin
          if (steps_r != '0) begin
            ready_nxt   = 1'b1;
            rst_act_nxt = (rst_cd_r != '0);
            nmi_act_nxt = (nmi_cd_r != '0);
            irq_act_nxt = (irq_cd_r != '0);
            if (rst_cd_r != '0) rst_cd_nxt = rst_cd_r - COUNT_W'(1);
            if (nmi_cd_r != '0) nmi_cd_nxt = nmi_cd_r - COUNT_W'(1);
            if (irq_cd_r != '0) irq_cd_nxt = irq_cd_r - COUNT_W'(1);
            steps_nxt = steps_r - COUNT_W'(1);
          end else begin
            ready_nxt = 1'b0;
          end
        end
        ACT_LOAD_RESET: rst_cd_nxt = sat;
        ACT_LOAD_NMI:   nmi_cd_nxt = sat;
        ACT_LOAD_IRQ:   irq_cd_nxt = sat;
        ACT_LOAD_STEPS: begin
          if (count_value == '0 || count_value > COUNT_W'(STEP_LIMIT)) begin
            steps_nxt = COUNT_W'(1);
          end else begin
            steps_nxt = count_value;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rst_cd_r  <= RST_CD_INIT;
      nmi_cd_r  <= '0;
      irq_cd_r  <= '0;
      steps_r   <= COUNT_W'(1);
      ready_r   <= 1'b0;
      rst_act_r <= 1'b0;
      nmi_act_r <= 1'b0;
      irq_act_r <= 1'b0;
    end else begin
      rst_cd_r  <= rst_cd_nxt;
      nmi_cd_r  <= nmi_cd_nxt;
      irq_cd_r  <= irq_cd_nxt;
      steps_r   <= steps_nxt;
      ready_r   <= ready_nxt;
      rst_act_r <= rst_act_nxt;
      nmi_act_r <= nmi_act_nxt;
      irq_act_r <= irq_act_nxt;
    end
  end

  assign stat.ready     = ready_r;
  assign stat.reset_act = rst_act_r;
  assign stat.nmi_act   = nmi_act_r;
  assign stat.irq_act   = irq_act_r;
  assign stat.steps     = steps_r;

endmodule

// ----- sv/cpu_bus_memory_responder_core.sv -----
// Channel   | Ports                         | Transfer when
// ----------+-------------------------------+------------------------------
// input     | start, busy, in_item          | start && !busy at clk rise
// result    | out_valid, out_item           | out_valid at clk rise
// config    | cfg_we, cfg_index, cfg_wdata  | cfg_we at clk rise
//
// One item per clock once busy is low; each result comes from registers
// loaded on the edge that takes its item. The single byte-store port
// allows this: one read or one write per cycle, read data registered.
// Reset (rst_n low, synchronous) holds busy high; busy is registered and
// clears once rst_n is high, then stays low. The store is not cleared.
// The receiver cannot stall: each result strobe lasts exactly one cycle.
module cpu_bus_memory_responder_core
  import cbmr_pkg::*;
#(
  parameter int STORE_DEPTH = CBMR_STORE_DEPTH,
  parameter int STEP_LIMIT  = CBMR_STEP_LIMIT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic       busy_r;
  logic       out_valid_r;
  logic       rd_flag_r;
  logic       bank_en_r;
  logic [7:0] host_bank_r;

  logic              accept;
  logic              is_bus;
  logic              is_host;
  logic [7:0]        bank_sel;
  logic [ADDR_W-1:0] ea_raw;
  logic [ADDR_W-1:0] ea;
  logic              mem_we;
  logic              mem_re;
  logic [7:0]        mem_rdata;
  ctrl_stat_t        stat;

  assign accept  = start && !busy_r;
  assign busy    = busy_r;
  assign is_bus  = (in_item.action == ACT_BUS);
  assign is_host = (in_item.action == ACT_HOST_WRITE);

  // Bus cycles take the bank from the bus, host writes from the register.
  assign bank_sel = is_host ? host_bank_r : in_item.bank_byte;
  assign ea_raw   = {bank_en_r && (bank_sel != 8'd0), in_item.bus_address};
  // An upper-half address beyond a short store folds back to the lower half.
  assign ea = ({1'b0, ea_raw} >= (ADDR_W + 1)'(STORE_DEPTH)) ?
              {1'b0, in_item.bus_address} : ea_raw;

  assign mem_we = accept && ((is_bus && !in_item.is_read) || is_host);
  assign mem_re = accept && is_bus && in_item.is_read;

  // Config writes: only legal while idle, so no hazard with items in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_en_r   <= 1'b0;
      host_bank_r <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BANK_ENABLE: bank_en_r   <= cfg_wdata[0];
        REG_HOST_BANK:   host_bank_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= accept;
    end
  end

  // Only selects whether read data or zero goes out; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_flag_r <= is_bus && in_item.is_read;
    end
  end

  cbmr_store #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (ea[AW-1:0]),
    .wdata (in_item.data_byte),
    .rdata (mem_rdata)
  );

  // Line state updates on the accept edge, so it lines up with read data.
  cbmr_ctrl #(
    .STEP_LIMIT(STEP_LIMIT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .action      (in_item.action),
    .count_value (in_item.count_value),
    .stat        (stat)
  );

  assign out_valid             = out_valid_r;
  assign out_item.read_data    = rd_flag_r ? mem_rdata : 8'd0;
  assign out_item.ready_res    = stat.ready;
  assign out_item.reset_active = stat.reset_act;
  assign out_item.nmi_active   = stat.nmi_act;
  assign out_item.irq_active   = stat.irq_act;
  assign out_item.steps_left   = stat.steps;

endmodule

// ----- sv/cbmr_checker.sv -----
`include "cpu_bus_memory_responder_core_macros.svh"

module cbmr_checker
  import cbmr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  // Every accepted item yields exactly one result, in the next cycle.
  `CBMR_ASSERT_NEXT(a_result_follows, start && !busy, out_valid)
  `CBMR_ASSERT_NEXT(a_no_spurious, !(start && !busy), !out_valid)
  // Reset drops any pending result.
  `CBMR_ASSERT_NEXT_ANY(a_reset_clears, !rst_n, !out_valid)
  // Anything but a bus cycle answers with zero read data.
  `CBMR_ASSERT_NEXT(a_nonbus_zero, start && !busy && in_item.action != ACT_BUS,
                    out_item.read_data == 8'd0)

endmodule

bind cpu_bus_memory_responder_core cbmr_checker u_cbmr_checker (.*);

// ----- tb/sv/cbmr_bus_checker.sv -----
module cbmr_bus_checker
  import cbmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  out_item_t   out_item,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  output int unsigned outstanding,
  output int unsigned mismatches,
  output int unsigned results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // mirror of the block's state
  logic [7:0]         shadow_mem [CBMR_STORE_DEPTH];
  logic [COUNT_W-1:0] rst_cd, nmi_cd, irq_cd, budget;
  logic               lv_ready, lv_reset, lv_nmi, lv_irq;
  logic               bank_en;
  logic [7:0]         host_bank_q;

  out_item_t pending_results [$];

  function automatic logic [ADDR_W-1:0] store_index(logic [15:0] addr, logic [7:0] bank);
    logic [ADDR_W-1:0] a;
    a = {1'b0, addr};
    if (bank_en && bank != 8'd0) a[16] = 1'b1;
    if (a >= CBMR_STORE_DEPTH) a[16] = 1'b0;
    return a;
  endfunction

  // one transfer in, updated state and the line/budget snapshot out
  function automatic out_item_t bus_response(in_item_t it);
    out_item_t          r;
    logic [COUNT_W-1:0] sat;
    logic [ADDR_W-1:0]  a;
    r   = '0;
    sat = (it.count_value > COUNT_MAX) ? COUNT_MAX : it.count_value;
    case (it.action)
      ACT_BUS: begin
        if (budget != '0) begin
          lv_ready = 1'b1;
          lv_reset = (rst_cd != '0);
          if (lv_reset) rst_cd = rst_cd - 1'b1;
          lv_nmi = (nmi_cd != '0);
          if (lv_nmi) nmi_cd = nmi_cd - 1'b1;
          lv_irq = (irq_cd != '0);
          if (lv_irq) irq_cd = irq_cd - 1'b1;
          budget = budget - 1'b1;
        end else begin
          lv_ready = 1'b0;
        end
        a = store_index(it.bus_address, it.bank_byte);
        if (it.is_read) r.read_data = shadow_mem[a];
        else shadow_mem[a] = it.data_byte;
      end
      ACT_LOAD_RESET: rst_cd = sat;
      ACT_LOAD_NMI:   nmi_cd = sat;
      ACT_LOAD_IRQ:   irq_cd = sat;
      ACT_LOAD_STEPS: begin
        budget = (it.count_value == '0 || it.count_value > CBMR_STEP_LIMIT) ?
                 17'd1 : it.count_value;
      end
      ACT_HOST_WRITE: shadow_mem[store_index(it.bus_address, host_bank_q)] = it.data_byte;
      default: ;
    endcase
    r.ready_res    = lv_ready;
    r.reset_active = lv_reset;
    r.nmi_active   = lv_nmi;
    r.irq_active   = lv_irq;
    r.steps_left   = budget;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
             $realtime, results_seen, what, got, want);
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      rst_cd      = RST_CD_INIT;
      nmi_cd      = '0;
      irq_cd      = '0;
      budget      = 17'd1;
      lv_ready    = 1'b0;
      lv_reset    = 1'b0;
      lv_nmi      = 1'b0;
      lv_irq      = 1'b0;
      bank_en     = 1'b0;
      host_bank_q = '0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BANK_ENABLE) bank_en = cfg_wdata[0];
        else host_bank_q = cfg_wdata;
      end
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_item.steps_left), '0);
        end else begin
          want = pending_results.pop_front();
          if (out_item.read_data !== want.read_data)
            report_mismatch("read_data", out_item.read_data, want.read_data);
          if (out_item.ready_res !== want.ready_res)
            report_mismatch("ready_res", out_item.ready_res, want.ready_res);
          if (out_item.reset_active !== want.reset_active)
            report_mismatch("reset_active", out_item.reset_active, want.reset_active);
          if (out_item.nmi_active !== want.nmi_active)
            report_mismatch("nmi_active", out_item.nmi_active, want.nmi_active);
          if (out_item.irq_active !== want.irq_active)
            report_mismatch("irq_active", out_item.irq_active, want.irq_active);
          if (out_item.steps_left !== want.steps_left)
            report_mismatch("steps_left", out_item.steps_left, want.steps_left);
        end
        results_seen++;
      end
      if (start && !busy) pending_results.push_back(bus_response(in_item));
    end
    outstanding <= pending_results.size();
  end

endmodule

// ----- tb/sv/tb_cpu_bus_memory_responder_core.sv -----
module tb_cpu_bus_memory_responder_core;
  import cbmr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Action codes the block ignores; they still produce one result each.
  localparam logic [2:0] ACT_RSVD_A = 3'd6;
  localparam logic [2:0] ACT_RSVD_B = 3'd7;

  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 390;
  localparam int CYCLE_LIMIT  = 200000;  // ~2k items

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_wdata;

  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned cycle_count;

  // Stimulus-side bookkeeping: which store entries hold data, so that a read
  // never touches an entry that was never written, and the current bank setup.
  bit                 written_map [CBMR_STORE_DEPTH];
  logic [ADDR_W-1:0]  written_list [$];
  logic               cur_bank_en;
  logic [7:0]         cur_host_bank;
  int unsigned        act_count [8];

  cpu_bus_memory_responder_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Watches all three channels, predicts every result and compares.
  cbmr_bus_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .outstanding  (outstanding),
    .mismatches   (mismatches),
    .results_seen (results_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hang guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Store entry hit by an access; the store is full size, so bit 16 is never dropped.
  function automatic logic [ADDR_W-1:0] store_slot(logic [15:0] addr, logic [7:0] bank);
    return {cur_bank_en && bank != 8'd0, addr};
  endfunction

  task automatic note_written(logic [ADDR_W-1:0] a);
    if (!written_map[a]) begin
      written_map[a] = 1'b1;
      written_list.push_back(a);
    end
  endtask

  // Presents one item and holds it until the transfer happens. start is left
  // high so the next call can follow back to back without a dip.
  task automatic send_item(in_item_t it);
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    act_count[it.action]++;
    if (it.action == ACT_BUS && !it.is_read)
      note_written(store_slot(it.bus_address, it.bank_byte));
    else if (it.action == ACT_HOST_WRITE)
      note_written(store_slot(it.bus_address, cur_host_bank));
  endtask

  task automatic idle_gap(int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Sender holds off until every issued item has produced its result.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Writes both registers, one after the other; only called with the block drained.
  task automatic set_config(logic be, logic [7:0] hb);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BANK_ENABLE;
    cfg_wdata <= {7'd0, be};
    @(posedge clk);
    cfg_index <= REG_HOST_BANK;
    cfg_wdata <= hb;
    @(posedge clk);
    cfg_we        <= 1'b0;
    cur_bank_en   = be;
    cur_host_bank = hb;
  endtask

  function automatic in_item_t mk(logic [2:0] act, logic [15:0] addr, logic [7:0] bank,
                                  logic rd, logic [7:0] data, logic [COUNT_W-1:0] cnt);
    in_item_t it;
    it.action      = act;
    it.bus_address = addr;
    it.bank_byte   = bank;
    it.is_read     = rd;
    it.data_byte   = data;
    it.count_value = cnt;
    return it;
  endfunction

  // Load counts: mostly short so lines and ready toggle often; sometimes the
  // saturation boundary, above it, or the full 17-bit range.
  function automatic logic [COUNT_W-1:0] random_count();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return $urandom_range(0, 12);
    if (pick < 70) return COUNT_MAX;
    if (pick < 80) return $urandom_range(CBMR_STEP_LIMIT + 1, 17'h1ffff);
    if (pick < 85) return '0;
    return $urandom_range(0, 17'h1ffff);
  endfunction

  function automatic in_item_t random_item();
    in_item_t          it;
    int unsigned       pick;
    logic [ADDR_W-1:0] a;
    // every field gets random content first, the action mix overrides
    it.bus_address = $urandom_range(0, 16'hffff);
    it.bank_byte   = $urandom_range(0, 1) ? $urandom_range(0, 255) : 8'd0;
    it.is_read     = $urandom_range(0, 1);
    it.data_byte   = $urandom_range(0, 255);
    it.count_value = $urandom_range(0, 17'h1ffff);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      it.action  = ACT_BUS;
      it.is_read = 1'b0;
      if ($urandom_range(0, 1) && written_list.size() > 0) begin
        a = written_list[$urandom_range(0, written_list.size() - 1)];
        // upper-half data is only reachable with banking on
        if (!(a[16] && !cur_bank_en)) begin
          it.is_read     = 1'b1;
          it.bus_address = a[15:0];
          if (a[16]) it.bank_byte = $urandom_range(1, 255);
          else if (cur_bank_en) it.bank_byte = 8'd0;
        end
      end
    end else if (pick < 70) begin
      it.action = ACT_HOST_WRITE;
    end else if (pick < 75) begin
      it.action      = ACT_LOAD_RESET;
      it.count_value = random_count();
    end else if (pick < 80) begin
      it.action      = ACT_LOAD_NMI;
      it.count_value = random_count();
    end else if (pick < 85) begin
      it.action      = ACT_LOAD_IRQ;
      it.count_value = random_count();
    end else if (pick < 95) begin
      it.action      = ACT_LOAD_STEPS;
      it.count_value = random_count();
    end else begin
      it.action = $urandom_range(0, 1) ? ACT_RSVD_A : ACT_RSVD_B;
    end
    return it;
  endfunction

  initial begin : stimulus
    int unsigned burst_left;
    int unsigned gap_max;
    logic        be;
    logic [7:0]  hb;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_item       <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_BANK_ENABLE;
    cfg_wdata     <= '0;
    cur_bank_en   = 1'b0;
    cur_host_bank = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // busy stays high through reset and clears once rst_n is high
    do @(posedge clk); while (busy);

    // Directed: out of reset the budget is one step and reset runs for six.
    send_item(mk(ACT_HOST_WRITE, 16'h0000, 8'h00, 1'b0, 8'h00, '0));
    send_item(mk(ACT_HOST_WRITE, 16'hffff, 8'hff, 1'b1, 8'hff, 17'h1ffff));
    send_item(mk(ACT_BUS, 16'h0000, 8'hff, 1'b1, 8'hff, '0));       // uses the only step
    send_item(mk(ACT_BUS, 16'hffff, 8'h00, 1'b1, 8'h00, '0));       // no steps: ready drops
    send_item(mk(ACT_LOAD_STEPS, 16'h0000, 8'h00, 1'b0, 8'h00, '0)); // zero becomes one
    send_item(mk(ACT_BUS, 16'h1234, 8'h00, 1'b0, 8'ha5, '0));
    send_item(mk(ACT_LOAD_STEPS, 16'h0000, 8'h00, 1'b0, 8'h00, 17'h1ffff)); // too big: one
    send_item(mk(ACT_LOAD_STEPS, 16'h0000, 8'h00, 1'b0, 8'h00, COUNT_MAX));
    send_item(mk(ACT_LOAD_RESET, 16'h0000, 8'h00, 1'b0, 8'h00, 17'h1ffff)); // saturates
    send_item(mk(ACT_LOAD_RESET, 16'h0000, 8'h00, 1'b0, 8'h00, '0));
    send_item(mk(ACT_LOAD_NMI, 16'h0000, 8'h00, 1'b0, 8'h00, COUNT_MAX));
    send_item(mk(ACT_LOAD_NMI, 16'h0000, 8'h00, 1'b0, 8'h00, 17'd1));
    send_item(mk(ACT_LOAD_IRQ, 16'h0000, 8'h00, 1'b0, 8'h00, 17'd2));
    send_item(mk(ACT_BUS, 16'h1234, 8'h00, 1'b1, 8'h00, '0));       // nmi and irq active
    send_item(mk(ACT_BUS, 16'hffff, 8'h00, 1'b1, 8'h00, '0));       // irq only
    send_item(mk(ACT_BUS, 16'hffff, 8'h01, 1'b0, 8'h5a, '0));       // bank byte ignored
    send_item(mk(ACT_RSVD_A, 16'hffff, 8'hff, 1'b1, 8'hff, 17'h1ffff));
    send_item(mk(ACT_RSVD_B, 16'h0000, 8'h00, 1'b0, 8'h00, '0));
    send_item(mk(ACT_LOAD_STEPS, 16'h0000, 8'h00, 1'b0, 8'h00, 17'd1));
    send_item(mk(ACT_BUS, 16'hffff, 8'h00, 1'b1, 8'h00, '0));
    send_item(mk(ACT_BUS, 16'hffff, 8'h00, 1'b1, 8'h00, '0));       // out of steps, levels held
    drain();
    // Banking on: host writes land in the upper half, nonzero bank reads it back.
    set_config(1'b1, 8'hff);
    send_item(mk(ACT_HOST_WRITE, 16'hffff, 8'h00, 1'b0, 8'hc3, '0));
    send_item(mk(ACT_BUS, 16'hffff, 8'h80, 1'b1, 8'h00, '0));       // access even with no steps
    send_item(mk(ACT_BUS, 16'hffff, 8'h00, 1'b1, 8'h00, '0));
    send_item(mk(ACT_LOAD_IRQ, 16'h0000, 8'h00, 1'b0, 8'h00, '0));

    // Random phases, one bank setup each; the first runs with no idling.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin be = 1'b0; hb = 8'h00; end
        1:       begin be = 1'b1; hb = 8'h00; end
        2:       begin be = 1'b1; hb = 8'hff; end
        3:       begin be = 1'b0; hb = 8'hff; end
        default: begin be = 1'b1; hb = $urandom_range(1, 254); end
      endcase
      gap_max = (p == 0) ? 0 : 6;
      drain();
      set_config(be, hb);
      burst_left = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == PHASE_ITEMS / 2) drain();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          idle_gap($urandom_range(0, gap_max));
        end
        send_item(random_item());
        burst_left--;
      end
    end

    // Wind down: every result due, then a short idle wait for anything stray.
    drain();
    repeat (4) @(posedge clk);
    $display("covered %0d bus cycles, %0d host writes, %0d loads, %0d ignored actions",
             act_count[ACT_BUS], act_count[ACT_HOST_WRITE],
             act_count[ACT_LOAD_RESET] + act_count[ACT_LOAD_NMI] +
             act_count[ACT_LOAD_IRQ] + act_count[ACT_LOAD_STEPS],
             act_count[ACT_RSVD_A] + act_count[ACT_RSVD_B]);
    $display("%0d results checked over %0d bank setups, %0d mismatches",
             results_seen, PHASES + 1, mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/cbmr_pkg.sv
sv/cbmr_store.sv
sv/cbmr_ctrl.sv
sv/cpu_bus_memory_responder_core.sv
sv/cbmr_checker.sv
tb/sv/cbmr_bus_checker.sv
tb/sv/tb_cpu_bus_memory_responder_core.sv
